// ===== rtl/pprt_pkg.sv =====
package pprt_pkg;

  localparam int AMT_W    = 48;
  localparam int PRICE_W  = 32;
  localparam int PNL_W    = 64;
  localparam int CNT_W    = 32;
  localparam int MAXPOS_W = 47;
  localparam int PCNT_W   = 7;
  localparam int CFG_W    = 47;

  localparam logic [1:0] REQ_SUBMIT = 2'd0;
  localparam logic [1:0] REQ_FILL   = 2'd1;
  localparam logic [1:0] REQ_MARK   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] ST_FILLED  = 3'd0;
  localparam logic [2:0] ST_BAD_AMT = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_LIMIT   = 3'd3;
  localparam logic [2:0] ST_APPLIED = 3'd4;
  localparam logic [2:0] ST_MARKED  = 3'd5;
  localparam logic [2:0] ST_ABSENT  = 3'd6;

  localparam logic CFG_MAX_POSITION = 1'b0;
  localparam logic CFG_PAIR_COUNT   = 1'b1;

  localparam logic [MAXPOS_W-1:0] MAX_POSITION_RST = 47'd100000000000;
  localparam logic [49:0]         DUST_LIMIT       = 50'd100;
  localparam logic [31:0]         SPREAD_SCALE     = 32'd1000000;

  typedef struct packed {
    logic signed [AMT_W-1:0] pos;
    logic [PRICE_W-1:0]      avg;
    logic signed [PNL_W-1:0] rel;
    logic signed [PNL_W-1:0] unr;
    logic [CNT_W-1:0]        cnt;
  } entry_t;

endpackage

// ===== rtl/pprt_req_if.sv =====
interface pprt_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          req_type;
  logic [5:0]                          pair_index;
  logic                                side;
  logic signed [pprt_pkg::AMT_W-1:0]   amount;
  logic [pprt_pkg::PRICE_W-1:0]        price;
  logic [pprt_pkg::PRICE_W-1:0]        mid;

  modport source (output valid, req_type, pair_index, side, amount, price, mid, input ready);
  modport sink (input valid, req_type, pair_index, side, amount, price, mid, output ready);
endinterface

// ===== rtl/pprt_rsp_if.sv =====
interface pprt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          status;
  logic [31:0]                         order_ref;
  logic [31:0]                         spread_centi_bps;
  logic signed [pprt_pkg::AMT_W-1:0]   position;
  logic [pprt_pkg::PRICE_W-1:0]        avg_price;
  logic signed [pprt_pkg::PNL_W-1:0]   pnl_closed;
  logic signed [pprt_pkg::PNL_W-1:0]   pnl_open;
  logic [pprt_pkg::CNT_W-1:0]          fills;

  modport source (output valid, status, order_ref, spread_centi_bps, position, avg_price,
                  pnl_closed, pnl_open, fills, input ready);
  modport sink (input valid, status, order_ref, spread_centi_bps, position, avg_price,
                pnl_closed, pnl_open, fills, output ready);
endinterface

// ===== rtl/pprt_ram.sv =====
module pprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/position_pnl_risk_tracker_top.sv =====
// Keeps a position, average entry price, realised and unrealised PnL and a fill count for each
// currency pair in one synchronous table, and takes one request at a time: order submission with
// a pre-trade check, direct fill, or mark to market. A request is read, worked on and, if it
// changes the entry, written back before the next is taken. A rejected order, a mark of an absent
// pair or an unused request type goes straight to its result. A mark may multiply for its open
// PnL; a fill that closes part of a position multiplies for its realised PnL, and one that adds
// to a position takes its average price through a bit-serial divider of 81 steps; a filled order
// with a non-zero mid also forms its spread figure with the same divider. A new request can be
// taken in the cycle in which the result appears. The result register lets the next request be
// taken while a result still waits to be transferred.
module position_pnl_risk_tracker_top #(
  parameter int NUM_PAIRS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pprt_pkg::CFG_W-1:0]    cfg_data,
  pprt_req_if.sink                      req,
  pprt_rsp_if.source                    rsp
);

  localparam int AW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int NW = $clog2(NUM_PAIRS + 128);
  localparam int EW = $bits(pprt_pkg::entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DECIDE, S_MUL, S_DIV, S_SPREAD, S_SPREADQ, S_FILL, S_PNL,
    S_AVGSET, S_AVG2, S_AVGDIV, S_MARK, S_WRITE, S_DONE
  } state_t;

  state_t state, mret, dret;

  logic [pprt_pkg::MAXPOS_W-1:0] max_position;
  logic [pprt_pkg::PCNT_W-1:0]   pair_count;
  logic [31:0]                   next_trade;
  logic [NUM_PAIRS-1:0]          vld;

  logic [1:0]         rtype;
  logic [5:0]         pidx;
  logic [AW-1:0]      addr;
  logic signed [47:0] amount;
  logic signed [48:0] s;
  logic [31:0]        price, mid;

  logic signed [47:0] pos;
  logic [31:0]        avg;
  logic signed [63:0] rel, unr;
  logic [31:0]        cnt;
  logic [2:0]         status;
  logic [31:0]        tid, spread;
  logic               report;

  logic [47:0] ma;
  logic [31:0] mb;
  logic [80:0] acc;
  logic        mph;

  logic [80:0] num;
  logic [48:0] den;
  logic [49:0] rem;
  logic [32:0] q;
  logic        qovf;
  logic [6:0]  dcnt;

  pprt_pkg::entry_t rd_entry, wr_entry;
  logic [EW-1:0]    rdata;
  logic             ram_we;

  logic               in_table, known_ok, entry_ok;
  logic [NW-1:0]      known;
  logic signed [49:0] pos_x, s_x, np;
  logic [49:0]        pos_abs, s_abs, np_abs;
  logic [47:0]        cl;
  logic signed [32:0] diff, mdiff;
  logic [31:0]        diff_abs, mdiff_abs, pm_abs;
  logic               reduce, adds, dust, flip, pnl_neg, mark_neg;
  logic [48:0]        dsum;
  logic signed [47:0] np_sat;
  logic [31:0]        fill_avg, divq;
  logic [55:0]        pp;
  logic [80:0]        acc_add;
  logic [49:0]        rs;
  logic               ge;
  logic               is_fill;

  function automatic logic [49:0] abs50(input logic signed [49:0] v);
    return v[49] ? 50'(-v) : 50'(v);
  endfunction

  function automatic logic signed [63:0] sat64(input logic [80:0] m, input logic neg);
    logic [80:0] lim;
    lim = 81'd1 << 63;
    if (neg) begin
      return (m >= lim) ? {1'b1, 63'd0} : 64'(-m[63:0]);
    end
    return (m >= lim) ? {1'b0, {63{1'b1}}} : m[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t[64] != t[63]) begin
      return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return t[63:0];
  endfunction

  assign in_table = NW'(pidx) < NW'(NUM_PAIRS);
  assign known    = (NW'(pair_count) < NW'(NUM_PAIRS)) ? NW'(pair_count) : NW'(NUM_PAIRS);
  assign known_ok = NW'(pidx) < known;
  assign entry_ok = in_table && vld[addr];

  assign pos_x   = 50'(pos);
  assign s_x     = 50'(s);
  assign np      = pos_x + s_x;
  assign pos_abs = abs50(pos_x);
  assign s_abs   = abs50(s_x);
  assign np_abs  = abs50(np);
  assign cl      = (s_abs < pos_abs) ? s_abs[47:0] : pos_abs[47:0];
  assign dsum    = pos_abs[48:0] + s_abs[48:0];

  assign diff      = $signed({1'b0, price}) - $signed({1'b0, avg});
  assign diff_abs  = diff[32] ? 32'(-diff) : diff[31:0];
  assign mdiff     = $signed({1'b0, mid}) - $signed({1'b0, avg});
  assign mdiff_abs = mdiff[32] ? 32'(-mdiff) : mdiff[31:0];
  assign pm_abs    = (price > mid) ? price - mid : mid - price;

  assign reduce   = (pos > 0 && s < 0) || (pos < 0 && s > 0);
  assign adds     = (pos >= 0 && s > 0) || (pos <= 0 && s < 0);
  assign dust     = np_abs < pprt_pkg::DUST_LIMIT;
  assign flip     = !dust && ((pos > 0 && np < 0) || (pos < 0 && np > 0));
  assign pnl_neg  = (pos > 0 && diff < 0) || (pos < 0 && diff > 0);
  assign mark_neg = pos[47] != mdiff[32];

  assign np_sat = dust ? 48'sd0
                : (np > 50'sd140737488355327)  ? 48'sh7FFF_FFFF_FFFF
                : (np < -50'sd140737488355328) ? 48'sh8000_0000_0000
                : np[47:0];

  assign divq     = (qovf || q[32]) ? 32'hFFFF_FFFF : q[31:0];
  assign fill_avg = dust ? 32'd0 : flip ? price : adds ? divq : avg;

  assign pp      = (mph ? ma[47:24] : ma[23:0]) * mb;
  assign acc_add = acc + (mph ? 81'({pp, 24'd0}) : 81'(pp));

  assign rs = {rem[48:0], num[80]};
  assign ge = rs >= {1'b0, den};

  assign is_fill = rtype == pprt_pkg::REQ_SUBMIT || rtype == pprt_pkg::REQ_FILL;

  assign rd_entry     = rdata;
  assign wr_entry.pos = is_fill ? np_sat : pos;
  assign wr_entry.avg = is_fill ? fill_avg : avg;
  assign wr_entry.rel = rel;
  assign wr_entry.unr = unr;
  assign wr_entry.cnt = is_fill ? cnt + 32'd1 : cnt;
  assign ram_we       = state == S_WRITE;

  assign req.ready = state == S_IDLE && !rst;

  pprt_ram #(.WIDTH(EW), .DEPTH(NUM_PAIRS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (wr_entry),
    .re    (req.valid && req.ready),
    .raddr (AW'(req.pair_index)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mret         <= S_IDLE;
      dret         <= S_IDLE;
      max_position <= pprt_pkg::MAX_POSITION_RST;
      pair_count   <= '0;
      next_trade   <= '0;
      vld          <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pprt_pkg::CFG_MAX_POSITION: max_position <= cfg_data;
          pprt_pkg::CFG_PAIR_COUNT:   pair_count   <= cfg_data[pprt_pkg::PCNT_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            rtype  <= req.req_type;
            pidx   <= req.pair_index;
            addr   <= AW'(req.pair_index);
            amount <= req.amount;
            s      <= req.side ? -49'(req.amount) : 49'(req.amount);
            price  <= req.price;
            mid    <= req.mid;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          pos    <= entry_ok ? rd_entry.pos : '0;
          avg    <= entry_ok ? rd_entry.avg : '0;
          rel    <= entry_ok ? rd_entry.rel : '0;
          unr    <= entry_ok ? rd_entry.unr : '0;
          cnt    <= entry_ok ? rd_entry.cnt : '0;
          tid    <= '0;
          spread <= '0;
          report <= in_table;
          state  <= S_DECIDE;
        end
        S_DECIDE: begin
          unique case (rtype)
            pprt_pkg::REQ_SUBMIT: begin
              if (amount <= 0) begin
                status <= pprt_pkg::ST_BAD_AMT;
                state  <= S_DONE;
              end else if (!known_ok) begin
                status <= pprt_pkg::ST_UNKNOWN;
                state  <= S_DONE;
              end else if (np_abs > 50'(max_position)) begin
                status <= pprt_pkg::ST_LIMIT;
                state  <= S_DONE;
              end else begin
                status     <= pprt_pkg::ST_FILLED;
                tid        <= next_trade;
                next_trade <= next_trade + 32'd1;
                if (mid == '0) begin
                  spread <= 32'hFFFF_FFFF;
                  state  <= S_FILL;
                end else begin
                  ma    <= 48'(pm_abs);
                  mb    <= pprt_pkg::SPREAD_SCALE;
                  acc   <= '0;
                  mph   <= 1'b0;
                  mret  <= S_SPREAD;
                  state <= S_MUL;
                end
              end
            end
            pprt_pkg::REQ_FILL: begin
              if (!in_table) begin
                status <= pprt_pkg::ST_UNKNOWN;
                state  <= S_DONE;
              end else begin
                status <= pprt_pkg::ST_APPLIED;
                state  <= S_FILL;
              end
            end
            pprt_pkg::REQ_MARK: begin
              if (!entry_ok) begin
                status <= pprt_pkg::ST_ABSENT;
                report <= 1'b0;
                state  <= S_DONE;
              end else begin
                status <= pprt_pkg::ST_MARKED;
                if (pos_abs > pprt_pkg::DUST_LIMIT && avg != '0) begin
                  ma    <= pos_abs[47:0];
                  mb    <= mdiff_abs;
                  acc   <= '0;
                  mph   <= 1'b0;
                  mret  <= S_MARK;
                  state <= S_MUL;
                end else begin
                  unr   <= '0;
                  state <= S_WRITE;
                end
              end
            end
            default: begin
              status <= pprt_pkg::ST_ABSENT;
              report <= 1'b0;
              state  <= S_DONE;
            end
          endcase
        end
        S_MUL: begin
          acc <= acc_add;
          mph <= 1'b1;
          if (mph) begin
            state <= mret;
          end
        end
        S_DIV: begin
          rem  <= ge ? rs - {1'b0, den} : rs;
          num  <= {num[79:0], 1'b0};
          qovf <= qovf | q[32];
          q    <= {q[31:0], ge};
          dcnt <= dcnt - 7'd1;
          if (dcnt == '0) begin
            state <= dret;
          end
        end
        S_SPREAD: begin
          num   <= acc + 81'(mid >> 1);
          den   <= 49'(mid);
          rem   <= '0;
          q     <= '0;
          qovf  <= 1'b0;
          dcnt  <= 7'd80;
          dret  <= S_SPREADQ;
          state <= S_DIV;
        end
        S_SPREADQ: begin
          spread <= divq;
          state  <= S_FILL;
        end
        S_FILL: begin
          if (reduce) begin
            ma    <= cl;
            mb    <= diff_abs;
            acc   <= '0;
            mph   <= 1'b0;
            mret  <= S_PNL;
            state <= S_MUL;
          end else begin
            state <= S_AVGSET;
          end
        end
        S_PNL: begin
          rel   <= add_sat(rel, sat64(acc, pnl_neg));
          state <= S_AVGSET;
        end
        S_AVGSET: begin
          if (!dust && adds) begin
            ma    <= pos_abs[47:0];
            mb    <= avg;
            acc   <= '0;
            mph   <= 1'b0;
            mret  <= S_AVG2;
            state <= S_MUL;
          end else begin
            state <= S_WRITE;
          end
        end
        S_AVG2: begin
          ma    <= s_abs[47:0];
          mb    <= price;
          mph   <= 1'b0;
          mret  <= S_AVGDIV;
          state <= S_MUL;
        end
        S_AVGDIV: begin
          num   <= acc + 81'(dsum >> 1);
          den   <= dsum;
          rem   <= '0;
          q     <= '0;
          qovf  <= 1'b0;
          dcnt  <= 7'd80;
          dret  <= S_WRITE;
          state <= S_DIV;
        end
        S_MARK: begin
          unr   <= sat64(acc, mark_neg);
          state <= S_WRITE;
        end
        S_WRITE: begin
          pos <= wr_entry.pos;
          avg <= wr_entry.avg;
          cnt <= wr_entry.cnt;
          if (is_fill) begin
            vld[addr] <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid            <= 1'b1;
            rsp.status           <= status;
            rsp.order_ref        <= tid;
            rsp.spread_centi_bps <= spread;
            rsp.position         <= report ? pos : '0;
            rsp.avg_price        <= report ? avg : '0;
            rsp.pnl_closed       <= report ? rel : '0;
            rsp.pnl_open         <= report ? unr : '0;
            rsp.fills            <= report ? cnt : '0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/pprt_checker.sv =====
module pprt_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [pprt_pkg::CFG_W-1:0]   cfg_data,
  pprt_req_if                          req,
  pprt_rsp_if                          rsp,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic [2:0]                        status;
    logic [31:0]                       ref_no;
    logic [31:0]                       spread;
    logic signed [pprt_pkg::AMT_W-1:0] position;
    logic [pprt_pkg::PRICE_W-1:0]      avg_price;
    logic signed [pprt_pkg::PNL_W-1:0] realised;
    logic signed [pprt_pkg::PNL_W-1:0] unrealised;
    logic [pprt_pkg::CNT_W-1:0]        count;
  } pair_report_t;

  localparam logic signed [63:0] POS48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] POS48_MIN = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;

  logic                              held[64];
  logic signed [pprt_pkg::AMT_W-1:0] pos_book[64];
  logic [pprt_pkg::PRICE_W-1:0]      avg_book[64];
  logic signed [pprt_pkg::PNL_W-1:0] rel_book[64];
  logic signed [pprt_pkg::PNL_W-1:0] unr_book[64];
  logic [pprt_pkg::CNT_W-1:0]        cnt_book[64];
  logic [31:0]                       trade_seq;
  logic [pprt_pkg::MAXPOS_W-1:0]     limit_cfg;
  logic [pprt_pkg::PCNT_W-1:0]       pairs_cfg;
  pair_report_t                      expected_reports[$];

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] clamp_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    if (p[127:63] != {65{p[127]}})
      return p[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] clamp_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63])
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [31:0] blended_price(logic [63:0] w1, logic [31:0] p1,
                                                logic [63:0] w2, logic [31:0] p2);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    den = {64'd0, w1} + {64'd0, w2};
    if (den == 0)
      return p2;
    num = {64'd0, w1} * {96'd0, p1} + {64'd0, w2} * {96'd0, p2} + (den >> 1);
    q = num / den;
    return q > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [31:0] spread_figure(logic [31:0] price, logic [31:0] mid);
    logic [63:0] d;
    logic [63:0] q;
    if (mid == 0)
      return 32'hFFFF_FFFF;
    d = price > mid ? price - mid : mid - price;
    q = (d * 64'd1000000 + {33'd0, mid[31:1]}) / {32'd0, mid};
    return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic book_fill(int idx, logic signed [63:0] s, logic [31:0] price);
    logic signed [63:0] pos;
    logic signed [63:0] np;
    logic signed [63:0] diff;
    logic [63:0] closed;
    logic [31:0] avg;
    pos = pos_book[idx];
    avg = avg_book[idx];
    if ((pos > 0 && s < 0) || (pos < 0 && s > 0)) begin
      closed = magnitude(s) < magnitude(pos) ? magnitude(s) : magnitude(pos);
      diff = $signed({32'd0, price}) - $signed({32'd0, avg});
      rel_book[idx] = clamp_add(rel_book[idx], clamp_mul(closed, pos > 0 ? diff : -diff));
    end
    np = pos + s;
    if (magnitude(np) < 100) begin
      np = 0;
      avg = 0;
    end else if ((pos >= 0 && s > 0) || (pos <= 0 && s < 0)) begin
      avg = blended_price(magnitude(pos), avg, magnitude(s), price);
    end
    if ((pos > 0 && np < 0) || (pos < 0 && np > 0))
      avg = price;
    if (np > POS48_MAX)
      np = POS48_MAX;
    if (np < POS48_MIN)
      np = POS48_MIN;
    pos_book[idx] = np[pprt_pkg::AMT_W-1:0];
    avg_book[idx] = avg;
    cnt_book[idx] = cnt_book[idx] + 32'd1;
    held[idx] = 1'b1;
  endtask

  task automatic predict_request();
    pair_report_t r;
    logic signed [63:0] amt;
    logic signed [63:0] s;
    logic signed [63:0] pos;
    int idx;
    int known;
    bit show;
    idx = req.pair_index;
    amt = req.amount;
    s = req.side ? -amt : amt;
    known = pairs_cfg < 64 ? pairs_cfg : 64;
    show = 1'b1;
    r = '0;
    r.status = pprt_pkg::ST_ABSENT;
    pos = pos_book[idx];
    case (req.req_type)
      pprt_pkg::REQ_SUBMIT: begin
        if (amt <= 0)
          r.status = pprt_pkg::ST_BAD_AMT;
        else if (idx >= known)
          r.status = pprt_pkg::ST_UNKNOWN;
        else if (magnitude(pos + s) > {17'd0, limit_cfg})
          r.status = pprt_pkg::ST_LIMIT;
        else begin
          r.status = pprt_pkg::ST_FILLED;
          r.ref_no = trade_seq;
          trade_seq = trade_seq + 32'd1;
          r.spread = spread_figure(req.price, req.mid);
          book_fill(idx, s, req.price);
        end
      end
      pprt_pkg::REQ_FILL: begin
        r.status = pprt_pkg::ST_APPLIED;
        book_fill(idx, s, req.price);
      end
      pprt_pkg::REQ_MARK: begin
        if (!held[idx]) begin
          show = 1'b0;
        end else begin
          r.status = pprt_pkg::ST_MARKED;
          if (magnitude(pos) > 100 && avg_book[idx] > 0)
            unr_book[idx] = clamp_mul(pos, $signed({32'd0, req.mid}) -
                                           $signed({32'd0, avg_book[idx]}));
          else
            unr_book[idx] = 0;
        end
      end
      default: show = 1'b0;
    endcase
    if (show) begin
      r.position = pos_book[idx];
      r.avg_price = avg_book[idx];
      r.realised = rel_book[idx];
      r.unrealised = unr_book[idx];
      r.count = cnt_book[idx];
    end
    expected_reports.insert(expected_reports.size(), r);
  endtask

  task automatic compare_report();
    pair_report_t e;
    pair_report_t a;
    a.status = rsp.status;
    a.ref_no = rsp.order_ref;
    a.spread = rsp.spread_centi_bps;
    a.position = rsp.position;
    a.avg_price = rsp.avg_price;
    a.realised = rsp.pnl_closed;
    a.unrealised = rsp.pnl_open;
    a.count = rsp.fills;
    if (expected_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result transfer: %p", a);
    end else begin
      e = expected_reports[0];
      expected_reports.delete(0);
      if (e != a) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: expected %p actual %p", e, a);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 64; i++) begin
        held[i] = 1'b0;
        pos_book[i] = '0;
        avg_book[i] = '0;
        rel_book[i] = '0;
        unr_book[i] = '0;
        cnt_book[i] = '0;
      end
      trade_seq = 0;
      limit_cfg = pprt_pkg::MAX_POSITION_RST;
      pairs_cfg = '0;
      fail_count = 0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == pprt_pkg::CFG_MAX_POSITION)
          limit_cfg = cfg_data[pprt_pkg::MAXPOS_W-1:0];
        else
          pairs_cfg = cfg_data[pprt_pkg::PCNT_W-1:0];
      end
      if (rsp.valid && rsp.ready)
        compare_report();
      if (req.valid && req.ready)
        predict_request();
    end
    pending <= expected_reports.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic                       cfg_index;
  logic [pprt_pkg::CFG_W-1:0] cfg_data;
  int                         fail_count;
  int                         pending;
  int                         send_idle_pct;
  int                         stall_pct;
  int                         quiet_cycles;

  pprt_req_if req ();
  pprt_rsp_if rsp ();

  position_pnl_risk_tracker_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp)
  );

  pprt_checker u_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk)
    rsp.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (!rst && quiet_cycles >= 20000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] kind, logic [5:0] idx, logic sell,
                              logic signed [pprt_pkg::AMT_W-1:0] amt, logic [31:0] price,
                              logic [31:0] mid);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.pair_index <= idx;
    req.side <= sell;
    req.amount <= amt;
    req.price <= price;
    req.mid <= mid;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [pprt_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_price();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return 32'd95000 + $urandom_range(10000);
    if (r < 85)
      return $urandom;
    if (r < 95)
      return 32'd0;
    return 32'hFFFF_FFFF;
  endfunction

  task automatic random_request();
    logic [1:0] kind;
    logic [5:0] idx;
    logic signed [pprt_pkg::AMT_W-1:0] amt;
    logic [63:0] wide;
    int r;
    r = $urandom_range(99);
    kind = r < 45 ? pprt_pkg::REQ_SUBMIT : r < 75 ? pprt_pkg::REQ_FILL :
           r < 95 ? pprt_pkg::REQ_MARK : pprt_pkg::REQ_UNUSED;
    idx = $urandom_range(99) < 80 ? 6'($urandom_range(7)) : 6'($urandom);
    wide = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 65)
      amt = $urandom_range(1, 2000000);
    else if (r < 75)
      amt = -$signed(48'($urandom_range(0, 1000)));
    else if (r < 87)
      amt = $urandom_range(0, 150);
    else if (r < 95)
      amt = wide[pprt_pkg::AMT_W-1:0];
    else
      amt = {2'b01, wide[45:0]};
    send_request(kind, idx, $urandom_range(1), amt, pick_price(), pick_price());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = pprt_pkg::CFG_MAX_POSITION;
    cfg_data = '0;
    req.valid = 1'b0;
    req.req_type = pprt_pkg::REQ_SUBMIT;
    req.pair_index = '0;
    req.side = 1'b0;
    req.amount = '0;
    req.price = '0;
    req.mid = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd0, 1'b0, 48'sd1000, 32'd110000, 32'd110010);
    send_request(pprt_pkg::REQ_MARK, 6'd0, 1'b0, 48'sd0, 32'd0, 32'd100000);
    send_request(pprt_pkg::REQ_UNUSED, 6'd63, 1'b1, -48'sd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
    write_reg(pprt_pkg::CFG_PAIR_COUNT, 47'd127);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd0, 1'b0, 48'sd0, 32'd110000, 32'd110000);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd0, 1'b1, -48'sd5, 32'd110000, 32'd110000);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd0, 1'b0, 48'sd100000, 32'd110000, 32'd110010);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd0, 1'b0, 48'sd50000, 32'd120000, 32'd0);
    send_request(pprt_pkg::REQ_MARK, 6'd0, 1'b0, 48'sd0, 32'd0, 32'd130000);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd0, 1'b1, 48'sd200000, 32'd100000, 32'd100500);
    send_request(pprt_pkg::REQ_FILL, 6'd0, 1'b0, 48'sd49950, 32'd101000, 32'd0);
    send_request(pprt_pkg::REQ_MARK, 6'd0, 1'b0, 48'sd0, 32'd0, 32'd99000);
    send_request(pprt_pkg::REQ_FILL, 6'd1, 1'b0, 48'sd0, 32'd101000, 32'd0);
    send_request(pprt_pkg::REQ_MARK, 6'd1, 1'b0, 48'sd0, 32'd0, 32'd99000);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd2, 1'b0, 48'sh7FFF_FFFF_FFFF, 32'd1, 32'd1);
    send_request(pprt_pkg::REQ_FILL, 6'd63, 1'b0, 48'sh7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_request(pprt_pkg::REQ_FILL, 6'd63, 1'b0, 48'sh7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_request(pprt_pkg::REQ_MARK, 6'd63, 1'b0, 48'sd0, 32'd0, 32'd0);
    send_request(pprt_pkg::REQ_FILL, 6'd63, 1'b0, 48'sh8000_0000_0000, 32'd0, 32'd0);
    send_request(pprt_pkg::REQ_MARK, 6'd63, 1'b0, 48'sd0, 32'd0, 32'hFFFF_FFFF);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd63, 1'b1, 48'sd300, 32'hFFFF_FFFF, 32'd1);
    drain();
    write_reg(pprt_pkg::CFG_MAX_POSITION, 47'd0);
    send_request(pprt_pkg::REQ_SUBMIT, 6'd5, 1'b0, 48'sd1, 32'd100000, 32'd100000);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(pprt_pkg::CFG_MAX_POSITION, {47{1'b1}});
          write_reg(pprt_pkg::CFG_PAIR_COUNT, 47'd64);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          write_reg(pprt_pkg::CFG_MAX_POSITION, pprt_pkg::MAX_POSITION_RST);
          write_reg(pprt_pkg::CFG_PAIR_COUNT, 47'd16);
          send_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          write_reg(pprt_pkg::CFG_MAX_POSITION, 47'({$urandom, $urandom}));
          write_reg(pprt_pkg::CFG_PAIR_COUNT, 47'($urandom_range(0, 127)));
          send_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          write_reg(pprt_pkg::CFG_MAX_POSITION, 47'd50000000);
          write_reg(pprt_pkg::CFG_PAIR_COUNT, 47'd8);
          send_idle_pct = 9;
          stall_pct = 9;
        end
      endcase
      repeat (250) random_request();
      drain();
    end
    if (fail_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
